FILE: hw/rtl/ttlc_pkg.sv
// Shared types and constants for the target track lifecycle/confidence block.
// No dependencies; every other file of the block imports this package.
package ttlc_pkg;

  localparam int unsigned CONF_W    = 17;
  localparam int unsigned HIT_W     = 10;
  localparam int unsigned MISS_W    = 9;
  localparam int unsigned BOUND_W   = 4;
  localparam int unsigned CFG_W     = 8;
  localparam int unsigned CFG_IDX_W = 1;

  // Shared arithmetic unit widths. NUM_W covers the widest intermediate for a
  // window of up to 64 entries and must be even (two quotient bits a cycle).
  localparam int unsigned NUM_W   = 40;
  localparam int unsigned MUL_A_W = 26;
  localparam int unsigned K_W     = 11;
  localparam int unsigned D_W     = 10;
  localparam int unsigned OPND_W  = 32;

  localparam logic [CONF_W-1:0] ONE_Q = 17'h10000;

  localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_HITS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DROP_MISSES  = 1'b1;
  localparam logic [CFG_W-1:0]     CONFIRM_RESET    = 8'd5;
  localparam logic [CFG_W-1:0]     DROP_RESET       = 8'd10;

  // Blend factors as numerator (signed) / denominator pairs.
  localparam logic signed [K_W-1:0] K_ZERO        = 11'sd0;
  localparam logic signed [K_W-1:0] K_ONE         = 11'sd1;
  localparam logic        [D_W-1:0] D_ONE         = 10'd1;
  localparam logic signed [K_W-1:0] BASE_TRK_NUM  = 11'sd4;
  localparam logic signed [K_W-1:0] BASE_DET_NUM  = 11'sd2;
  localparam logic        [D_W-1:0] BASE_DEN      = 10'd5;
  localparam logic        [D_W-1:0] STAB_HALF_DEN = 10'd2;
  localparam logic signed [K_W-1:0] TL_FLOOR_NUM  = 11'sd3;
  localparam logic        [D_W-1:0] TL_FLOOR_DEN  = 10'd10;
  localparam logic signed [K_W-1:0] UNBOUND_NUM   = 11'sd7;
  localparam logic        [D_W-1:0] UNBOUND_DEN   = 10'd10;
  localparam logic signed [K_W-1:0] ONEBOUND_NUM  = 11'sd17;
  localparam logic        [D_W-1:0] ONEBOUND_DEN  = 10'd20;
  localparam logic signed [K_W-1:0] WIN_X_NUM     = 11'sd3;
  localparam int unsigned           WIN_MEAN_NUM  = 7;
  localparam logic        [D_W-1:0] WIN_DEN       = 10'd10;

  typedef enum logic [1:0] {
    PH_DETECTING = 2'd0,
    PH_TRACKING  = 2'd1,
    PH_TEMP_LOST = 2'd2,
    PH_LOST      = 2'd3
  } phase_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_UPDATE,
    SQ_LOAD,
    SQ_MUL,
    SQ_ADD,
    SQ_DIV,
    SQ_DIV_WAIT,
    SQ_EMIT
  } seq_t;

  typedef enum logic [1:0] {
    BS_BASE,
    BS_STAB,
    BS_BOUND,
    BS_WIN
  } step_t;

  typedef enum logic [2:0] {
    ALU_NOP,
    ALU_LOAD,
    ALU_MUL,
    ALU_ADD,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    alu_op_t                  op;
    logic signed [K_W-1:0]    k;
    logic [D_W-1:0]           d;
    logic signed [OPND_W-1:0] opnd;
  } alu_cmd_t;

  typedef struct packed {
    logic              step;
    logic              func;
    logic              matched;
    logic [CONF_W-1:0] conf;
  } life_cmd_t;

  typedef struct packed {
    phase_t            phase;
    logic [HIT_W-1:0]  hits;
    logic [MISS_W-1:0] misses;
    logic [CONF_W-1:0] last_conf;
  } life_st_t;

  typedef struct packed {
    logic              clear;
    logic              push;
    logic [CONF_W-1:0] value;
  } win_cmd_t;

endpackage

FILE: hw/rtl/ttlc_if.sv
// Valid/ready channel interfaces for the item and result beats.
// Depends on ttlc_pkg for field widths.
interface ttlc_item_if;
  import ttlc_pkg::*;
  logic               valid;
  logic               ready;
  logic               func;
  logic               matched;
  logic [CONF_W-1:0]  det_conf;
  logic [BOUND_W-1:0] bound_tracks;

  modport source (output valid, func, matched, det_conf, bound_tracks, input ready);
  modport sink   (input valid, func, matched, det_conf, bound_tracks, output ready);
endinterface

interface ttlc_result_if;
  import ttlc_pkg::*;
  logic              valid;
  logic              ready;
  logic [1:0]        phase;
  logic              is_tracking;
  logic              remove;
  logic [CONF_W-1:0] confidence;
  logic [HIT_W-1:0]  hit_count;
  logic [MISS_W-1:0] miss_count;

  modport source (output valid, phase, is_tracking, remove, confidence, hit_count,
                  miss_count, input ready);
  modport sink   (input valid, phase, is_tracking, remove, confidence, hit_count,
                  miss_count, output ready);
endinterface

FILE: hw/rtl/target_track_lifecycle_confidence.sv
// Target track lifecycle and confidence: top level with sequencer and output register.
// Depends on ttlc_pkg, ttlc_if, ttlc_window, ttlc_life and ttlc_alu.
//
// One item at a time. Each accepted beat either starts a track (func = 0) or
// reports a frame (func = 1); the phase machine and the confidence window are
// updated first, then a blended confidence is built in fixed point (65536 = 1.0)
// from a phase baseline, a stability factor, a binding factor and the window
// mean, each step truncated toward zero, and clamped to 0..65536. All blend
// arithmetic runs through one shared multiply/add/divide unit under a small
// sequencer: four multiply-then-divide steps, with an add before the last
// divide. The divider retires two quotient bits a cycle, and a division by one
// is skipped. The item port is ready again as soon as the result is loaded
// into the output register, even if that result has not been taken yet.
// Configuration writes (confirm_hits, drop_misses) take effect at once and
// are expected only while no item is in flight.
module target_track_lifecycle_confidence #(
  parameter int WINDOW_DEPTH = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [ttlc_pkg::CFG_IDX_W-1:0]    cfg_idx,
  input  logic [ttlc_pkg::CFG_W-1:0]        cfg_wdata,
  ttlc_item_if.sink                         item,
  ttlc_result_if.source                     result
);
  import ttlc_pkg::*;

  localparam int FILL_W = $clog2(WINDOW_DEPTH + 1);
  localparam int SUM_W  = CONF_W + FILL_W;

  // Configuration registers.
  logic [CFG_W-1:0] confirm_hits;
  logic [CFG_W-1:0] drop_misses;

  always_ff @(posedge clk) begin
    if (rst) begin
      confirm_hits <= CONFIRM_RESET;
      drop_misses  <= DROP_RESET;
    end else if (cfg_we) begin
      case (cfg_idx)
        REG_CONFIRM_HITS: confirm_hits <= cfg_wdata;
        REG_DROP_MISSES:  drop_misses  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Sequencer state and the captured item beat.
  seq_t               state, state_next;
  step_t              step, step_next;
  logic               func_q;
  logic               matched_q;
  logic [CONF_W-1:0]  conf_q;
  logic [BOUND_W-1:0] bound_q;
  logic               accept;
  logic [CONF_W-1:0]  conf_eff;

  assign item.ready = (state == SQ_IDLE);
  assign accept     = item.valid && item.ready;

  // No confidence (zero) or above one both count as one.
  assign conf_eff = (item.det_conf == '0 || item.det_conf > ONE_Q) ? ONE_Q : item.det_conf;

  always_ff @(posedge clk) begin
    if (accept) begin
      func_q    <= item.func;
      matched_q <= item.matched;
      conf_q    <= conf_eff;
      bound_q   <= item.bound_tracks;
    end
  end

  // Sub-units.
  life_cmd_t                life_cmd;
  life_st_t                 life_st;
  win_cmd_t                 win_cmd;
  logic [FILL_W-1:0]        win_fill;
  logic [SUM_W-1:0]         win_sum;
  alu_cmd_t                 alu_cmd;
  logic                     alu_busy;
  logic signed [NUM_W-1:0]  alu_num;

  ttlc_life u_life (
    .clk          (clk),
    .rst          (rst),
    .cmd          (life_cmd),
    .confirm_hits (confirm_hits),
    .drop_misses  (drop_misses),
    .st           (life_st)
  );

  ttlc_window #(
    .DEPTH (WINDOW_DEPTH)
  ) u_window (
    .clk  (clk),
    .rst  (rst),
    .cmd  (win_cmd),
    .fill (win_fill),
    .sum  (win_sum)
  );

  ttlc_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .cmd  (alu_cmd),
    .busy (alu_busy),
    .num  (alu_num)
  );

  // Blend factors for the current step, taken from the updated track state.
  logic [CFG_W-1:0]        mm;         // max(1, drop_misses)
  logic [CFG_W:0]          cc;         // max(1, 2 * confirm_hits)
  logic                    h_ge_c;
  logic                    two_h_lt_c;
  logic                    ten_h_lt_3c;
  logic signed [K_W-1:0]   fac_k;
  logic [D_W-1:0]          fac_d;
  logic [OPND_W-1:0]       win_add;

  assign mm          = (drop_misses == '0) ? CFG_W'(1) : drop_misses;
  assign cc          = (confirm_hits == '0) ? (CFG_W+1)'(1) : {confirm_hits, 1'b0};
  assign h_ge_c      = (life_st.hits >= {1'b0, cc});
  assign two_h_lt_c  = ({life_st.hits, 1'b0} < {2'b00, cc});
  assign ten_h_lt_3c = (({4'b0000, life_st.hits} * 14'd10) < ({5'b00000, cc} * 14'd3));

  always_comb begin
    fac_k   = K_ONE;
    fac_d   = D_ONE;
    win_add = '0;
    case (step)
      BS_BASE: begin
        case (life_st.phase)
          PH_TRACKING: begin
            fac_k = BASE_TRK_NUM;
            fac_d = BASE_DEN;
          end
          PH_DETECTING: begin
            fac_k = BASE_DET_NUM;
            fac_d = BASE_DEN;
          end
          PH_TEMP_LOST: begin
            // (M - misses) / (2M); negative once misses passes a lowered limit
            fac_k = $signed({3'b000, mm}) - $signed({2'b00, life_st.misses});
            fac_d = {1'b0, mm, 1'b0};
          end
          default: begin
            fac_k = K_ZERO;
          end
        endcase
      end
      BS_STAB: begin
        if (life_st.phase inside {PH_TRACKING, PH_DETECTING}) begin
          if (!h_ge_c) begin
            if (two_h_lt_c) begin
              fac_d = STAB_HALF_DEN;
            end else begin
              fac_k = $signed({1'b0, life_st.hits});
              fac_d = {1'b0, cc};
            end
          end
        end else if (life_st.phase == PH_TEMP_LOST) begin
          if (!h_ge_c) begin
            if (ten_h_lt_3c) begin
              fac_k = TL_FLOOR_NUM;
              fac_d = TL_FLOOR_DEN;
            end else begin
              fac_k = $signed({1'b0, life_st.hits});
              fac_d = {1'b0, cc};
            end
          end
        end
      end
      BS_BOUND: begin
        if (bound_q == '0) begin
          fac_k = UNBOUND_NUM;
          fac_d = UNBOUND_DEN;
        end else if (bound_q == BOUND_W'(1)) begin
          fac_k = ONEBOUND_NUM;
          fac_d = ONEBOUND_DEN;
        end
      end
      BS_WIN: begin
        // (3 * x * fill + 7 * sum) / (10 * fill)
        if (win_fill != '0) begin
          fac_k   = $signed(K_W'(win_fill) * K_W'(WIN_X_NUM));
          fac_d   = D_W'(win_fill) * WIN_DEN;
          win_add = OPND_W'(win_sum) * OPND_W'(WIN_MEAN_NUM);
        end
      end
      default: begin
      end
    endcase
  end

  function automatic step_t step_after(step_t s);
    case (s)
      BS_BASE:  return BS_STAB;
      BS_STAB:  return BS_BOUND;
      BS_BOUND: return BS_WIN;
      default:  return BS_WIN;
    endcase
  endfunction

  logic load_out;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SQ_IDLE;
      step  <= BS_BASE;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_comb begin
    state_next       = state;
    step_next        = step;
    life_cmd.step    = 1'b0;
    life_cmd.func    = func_q;
    life_cmd.matched = matched_q;
    life_cmd.conf    = conf_q;
    win_cmd.clear    = 1'b0;
    win_cmd.push     = 1'b0;
    win_cmd.value    = conf_q;
    alu_cmd.op       = ALU_NOP;
    alu_cmd.k        = fac_k;
    alu_cmd.d        = fac_d;
    alu_cmd.opnd     = '0;
    load_out         = 1'b0;
    case (state)
      SQ_IDLE: begin
        if (accept) begin
          state_next = SQ_UPDATE;
        end
      end
      SQ_UPDATE: begin
        // Advance the phase machine; a start clears the window, a start or a
        // matched frame records its confidence.
        life_cmd.step = 1'b1;
        win_cmd.clear = !func_q;
        win_cmd.push  = !func_q || matched_q;
        state_next    = SQ_LOAD;
      end
      SQ_LOAD: begin
        alu_cmd.op   = ALU_LOAD;
        alu_cmd.opnd = $signed(OPND_W'(life_st.last_conf));
        step_next    = BS_BASE;
        state_next   = SQ_MUL;
      end
      SQ_MUL: begin
        alu_cmd.op = ALU_MUL;
        state_next = (step == BS_WIN) ? SQ_ADD : SQ_DIV;
      end
      SQ_ADD: begin
        alu_cmd.op   = ALU_ADD;
        alu_cmd.opnd = $signed(win_add);
        state_next   = SQ_DIV;
      end
      SQ_DIV: begin
        if (fac_d != D_ONE) begin
          alu_cmd.op = ALU_DIV;
          state_next = SQ_DIV_WAIT;
        end else if (step == BS_WIN) begin
          state_next = SQ_EMIT;
        end else begin
          step_next  = step_after(step);
          state_next = SQ_MUL;
        end
      end
      SQ_DIV_WAIT: begin
        if (!alu_busy) begin
          if (step == BS_WIN) begin
            state_next = SQ_EMIT;
          end else begin
            step_next  = step_after(step);
            state_next = SQ_MUL;
          end
        end
      end
      SQ_EMIT: begin
        // Hold here while the previous result still occupies the output register.
        if (!result.valid || result.ready) begin
          load_out   = 1'b1;
          state_next = SQ_IDLE;
        end
      end
      default: begin
        state_next = SQ_IDLE;
      end
    endcase
  end

  // Output register: clamp the blend to 0..1.0 and capture the track state.
  logic [CONF_W-1:0] conf_clamped;

  assign conf_clamped = alu_num[NUM_W-1]            ? '0 :
                        (alu_num > NUM_W'(ONE_Q))   ? ONE_Q :
                                                      alu_num[CONF_W-1:0];

  logic              out_valid;
  phase_t            out_phase;
  logic [CONF_W-1:0] out_conf;
  logic [HIT_W-1:0]  out_hits;
  logic [MISS_W-1:0] out_misses;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_phase  <= life_st.phase;
      out_conf   <= conf_clamped;
      out_hits   <= life_st.hits;
      out_misses <= life_st.misses;
    end
  end

  assign result.valid       = out_valid;
  assign result.phase       = out_phase;
  assign result.is_tracking = (out_phase == PH_TRACKING || out_phase == PH_TEMP_LOST);
  assign result.remove      = (out_phase == PH_LOST);
  assign result.confidence  = out_conf;
  assign result.hit_count   = out_hits;
  assign result.miss_count  = out_misses;

  a_alu_idle_issue: assert property (@(posedge clk) disable iff (rst)
    (alu_cmd.op != ALU_NOP) |-> !alu_busy)
    else $error("arithmetic command issued while divider busy");

  a_emit_last_step: assert property (@(posedge clk) disable iff (rst)
    (state == SQ_EMIT) |-> (step == BS_WIN))
    else $error("result emitted before the window step");

  a_flags_exclusive: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.is_tracking && result.remove))
    else $error("tracking and remove flags both set");

endmodule

FILE: hw/rtl/ttlc_window.sv
// Sliding window of observed confidences with running sum and fill count.
// Depends on ttlc_pkg; a push first reads the oldest entry, then updates the window.
module ttlc_window #(
  parameter int DEPTH = 8
) (
  input  logic                         clk,
  input  logic                         rst,
  input  ttlc_pkg::win_cmd_t           cmd,
  output logic [$clog2(DEPTH+1)-1:0]   fill,
  output logic [ttlc_pkg::CONF_W+$clog2(DEPTH+1)-1:0] sum
);
  import ttlc_pkg::*;

  localparam int FILL_W = $clog2(DEPTH + 1);
  localparam int SUM_W  = CONF_W + FILL_W;
  localparam int PTR_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [CONF_W-1:0] mem [DEPTH];
  logic [CONF_W-1:0] rd;
  logic [CONF_W-1:0] pend_val;
  logic              pend;
  logic [PTR_W-1:0]  ptr;
  logic              full;

  assign full = (fill == FILL_W'(DEPTH));

  // Read the oldest entry on the command cycle, write the new one in the cycle after.
  always_ff @(posedge clk) begin
    if (cmd.push) begin
      rd <= mem[ptr];
    end
    if (pend) begin
      mem[ptr] <= pend_val;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      pend_val <= cmd.value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= 1'b0;
      ptr  <= '0;
      fill <= '0;
      sum  <= '0;
    end else begin
      pend <= cmd.push;
      if (cmd.clear) begin
        ptr  <= '0;
        fill <= '0;
        sum  <= '0;
      end else if (pend) begin
        if (full) begin
          sum <= sum - SUM_W'(rd) + SUM_W'(pend_val);
        end else begin
          fill <= fill + 1'b1;
          sum  <= sum + SUM_W'(pend_val);
        end
        ptr <= (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + 1'b1;
      end
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= FILL_W'(DEPTH))
    else $error("window fill count above depth");

endmodule

FILE: hw/rtl/ttlc_life.sv
// Track phase machine with hit/miss counters and last detector confidence.
// Depends on ttlc_pkg; the registered state updates on a step strobe.
module ttlc_life (
  input  logic                         clk,
  input  logic                         rst,
  input  ttlc_pkg::life_cmd_t          cmd,
  input  logic [ttlc_pkg::CFG_W-1:0]   confirm_hits,
  input  logic [ttlc_pkg::CFG_W-1:0]   drop_misses,
  output ttlc_pkg::life_st_t           st
);
  import ttlc_pkg::*;

  phase_t            phase, phase_next;
  logic [HIT_W-1:0]  hits, hits_next;
  logic [MISS_W-1:0] misses, misses_next;
  logic [CONF_W-1:0] last_conf, last_conf_next;

  logic [HIT_W-1:0]  cap;
  logic [HIT_W:0]    hits_inc;
  logic [HIT_W-1:0]  hits_capped;
  logic [MISS_W-1:0] misses_inc;

  assign cap         = {2'b00, confirm_hits} + {1'b0, confirm_hits, 1'b0};
  assign hits_inc    = {1'b0, hits} + 1'b1;
  assign hits_capped = (hits_inc < {1'b0, cap}) ? hits_inc[HIT_W-1:0] : cap;
  assign misses_inc  = misses + 1'b1;

  always_comb begin
    phase_next     = phase;
    hits_next      = hits;
    misses_next    = misses;
    last_conf_next = last_conf;
    if (cmd.step) begin
      if (!cmd.func) begin
        phase_next     = PH_DETECTING;
        hits_next      = '0;
        misses_next    = '0;
        last_conf_next = cmd.conf;
      end else begin
        if (cmd.matched) begin
          last_conf_next = cmd.conf;
        end
        case (phase)
          PH_DETECTING: begin
            if (cmd.matched) begin
              hits_next = hits_inc[HIT_W-1:0];
              if (hits_inc > {3'b000, confirm_hits}) begin
                phase_next = PH_TRACKING;
              end
            end else begin
              hits_next  = '0;
              phase_next = PH_LOST;
            end
          end
          PH_TRACKING: begin
            if (cmd.matched) begin
              hits_next = hits_capped;
            end else begin
              phase_next  = PH_TEMP_LOST;
              misses_next = misses_inc;
            end
          end
          PH_TEMP_LOST: begin
            if (!cmd.matched) begin
              misses_next = misses_inc;
              hits_next   = (hits == '0) ? '0 : hits - 1'b1;
              if (misses_inc > {1'b0, drop_misses}) begin
                misses_next = '0;
                hits_next   = '0;
                phase_next  = PH_LOST;
              end
            end else begin
              phase_next  = PH_TRACKING;
              misses_next = '0;
              hits_next   = hits_capped;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_LOST;
      hits      <= '0;
      misses    <= '0;
      last_conf <= ONE_Q;
    end else begin
      phase     <= phase_next;
      hits      <= hits_next;
      misses    <= misses_next;
      last_conf <= last_conf_next;
    end
  end

  assign st.phase     = phase;
  assign st.hits      = hits;
  assign st.misses    = misses;
  assign st.last_conf = last_conf;

  a_lost_clear: assert property (@(posedge clk) disable iff (rst)
    (phase == PH_LOST) |-> (hits == '0 && misses == '0))
    else $error("lost track holds nonzero counters");

  a_miss_phase: assert property (@(posedge clk) disable iff (rst)
    (misses != '0) |-> (phase == PH_TEMP_LOST))
    else $error("miss count outside temporary loss");

endmodule

FILE: hw/rtl/ttlc_alu.sv
// Shared arithmetic unit: load, multiply by a small factor, add, and an
// iterative divide by a positive divisor (two quotient bits per cycle, truncating
// toward zero). Depends on ttlc_pkg.
module ttlc_alu (
  input  logic                                 clk,
  input  logic                                 rst,
  input  ttlc_pkg::alu_cmd_t                   cmd,
  output logic                                 busy,
  output logic signed [ttlc_pkg::NUM_W-1:0]    num
);
  import ttlc_pkg::*;

  localparam int DIV_STEPS = NUM_W / 2;
  localparam int CNT_W     = $clog2(DIV_STEPS + 1);

  logic [NUM_W-1:0] quo, quo_next;
  logic [D_W-1:0]   rem, rem_next;
  logic [D_W-1:0]   dvs;
  logic             neg;
  logic [CNT_W-1:0] cnt;

  logic signed [MUL_A_W+K_W-1:0] prod;
  logic [D_W:0]                  r1, r2;
  logic [D_W-1:0]                r1s;
  logic                          q1, q2;

  assign busy = (cnt != '0);
  assign prod = $signed(num[MUL_A_W-1:0]) * $signed(cmd.k);

  // Two restoring steps per cycle.
  always_comb begin
    r1       = {rem, quo[NUM_W-1]};
    q1       = (r1 >= {1'b0, dvs});
    r1s      = q1 ? D_W'(r1 - {1'b0, dvs}) : r1[D_W-1:0];
    r2       = {r1s, quo[NUM_W-2]};
    q2       = (r2 >= {1'b0, dvs});
    rem_next = q2 ? D_W'(r2 - {1'b0, dvs}) : r2[D_W-1:0];
    quo_next = {quo[NUM_W-3:0], q1, q2};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt - 1'b1;
    end else if (cmd.op == ALU_DIV) begin
      cnt <= CNT_W'(DIV_STEPS);
    end
  end

  always_ff @(posedge clk) begin
    if (busy) begin
      quo <= quo_next;
      rem <= rem_next;
      if (cnt == CNT_W'(1)) begin
        num <= neg ? -$signed(quo_next) : $signed(quo_next);
      end
    end else begin
      case (cmd.op)
        ALU_LOAD: num <= NUM_W'(cmd.opnd);
        ALU_MUL:  num <= NUM_W'(prod);
        ALU_ADD:  num <= num + NUM_W'(cmd.opnd);
        ALU_DIV: begin
          neg <= num[NUM_W-1];
          quo <= num[NUM_W-1] ? NUM_W'(-num) : NUM_W'(num);
          rem <= '0;
          dvs <= cmd.d;
        end
        default: begin
        end
      endcase
    end
  end

endmodule
